// ===== sv/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types, constants and register indexes of the button event generator.
// ----------------------------------------------------------------------------
package bde_pkg;

   localparam int LANES            = 8;
   localparam int DEF_NUM_BUTTONS  = 8;
   localparam int TIME_W           = 32;
   localparam int TIMING_W         = 16;
   localparam int BTN_W            = 3;
   localparam int CSR_IDX_W        = 4;
   localparam int CSR_DATA_W       = 16;
   localparam int REQ_DATA_W       = 40;
   localparam int RSP_DATA_W       = 40;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_TIME   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS_TIME = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LEVELS   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BUTTON_COUNT    = 4'd3;

   localparam logic [TIMING_W-1:0] RST_DEBOUNCE_TIME   = 16'd20;
   localparam logic [TIMING_W-1:0] RST_LONG_PRESS_TIME = 16'd1000;
   localparam logic [LANES-1:0]    RST_ACTIVE_LEVELS   = 8'd0;
   localparam logic [3:0]          RST_BUTTON_COUNT    = 4'd8;

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_CLICK   = 2'd2,
      KIND_LONG    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEB,
      ST_CLICK,
      ST_LONG,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [BTN_W-1:0]  button_index;
      kind_type          kind;
      logic [TIME_W-1:0] event_time;
   } event_type;

   typedef struct packed {
      logic push;
      logic flush;
   } evq_ctl_type;

   typedef struct packed {
      logic push_ok;
      logic flush_ok;
   } evq_sts_type;

endpackage

// ===== sv/bde_cmp.sv =====
// ----------------------------------------------------------------------------
// bde_cmp
// Shared elapsed-time unit: modulo 2^32 difference against a 16-bit threshold.
// ----------------------------------------------------------------------------
module bde_cmp (
   input  logic [bde_pkg::TIME_W-1:0]   now_ms,
   input  logic [bde_pkg::TIME_W-1:0]   base_ms,
   input  logic [bde_pkg::TIMING_W-1:0] threshold,
   output logic                         reached
);
   import bde_pkg::*;

   logic [TIME_W-1:0] elapsed;

   assign elapsed = now_ms - base_ms;
   assign reached = elapsed >= {{(TIME_W-TIMING_W){1'b0}}, threshold};

endmodule

// ===== sv/bde_evq.sv =====
// ----------------------------------------------------------------------------
// bde_evq
// Event holding stage: keeps one pending event so the final one of a tick
// can be marked, and drives the registered result channel.
// ----------------------------------------------------------------------------
module bde_evq (
   input  logic                           clock,
   input  logic                           reset,
   input  bde_pkg::evq_ctl_type           ctl,
   input  bde_pkg::event_type             ev,
   output bde_pkg::evq_sts_type           sts,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bde_pkg::RSP_DATA_W-1:0] rsp_tdata,  // button_index, event_time
   output logic [1:0]                     rsp_tuser,  // event_kind
   output logic                           rsp_tlast
);
   import bde_pkg::*;

   logic      pend_valid_ff;
   event_type pend_ff;
   logic      out_valid_ff;
   event_type out_ff;
   logic      out_last_ff;
   logic      slot_free;
   logic      do_push;
   logic      do_flush;

   assign slot_free    = !out_valid_ff || rsp_tready;
   assign sts.push_ok  = slot_free || !pend_valid_ff;
   assign sts.flush_ok = slot_free || !pend_valid_ff;
   assign do_push      = ctl.push && sts.push_ok;
   assign do_flush     = ctl.flush && pend_valid_ff && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (do_flush || (do_push && pend_valid_ff)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (do_push) begin
            pend_valid_ff <= 1'b1;
         end else if (do_flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         pend_ff <= ev;
         if (pend_valid_ff) begin
            out_ff      <= pend_ff;
            out_last_ff <= 1'b0;
         end
      end else if (do_flush) begin
         out_ff      <= pend_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TIME_W-BTN_W){1'b0}}, out_ff.event_time,
                        out_ff.button_index};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/button_debounce_event_generator.sv =====
// ----------------------------------------------------------------------------
// button_debounce_event_generator
// Debounces up to eight buttons per time tick and emits press, release, click
// and long-press events, one button at a time through a shared time unit.
// ----------------------------------------------------------------------------
// Sequence: an accept step, then a debounce step and a long-press check per
//   button in use (a click takes the slot of the long-press check), then a
//   flush step; output stalls hold any push or flush. No new tick is taken
//   until the flush. Sequencer and single elapsed-time compare unit set the rate.
// Reset: synchronous; all button state cleared, registers to defaults.
// ----------------------------------------------------------------------------
module button_debounce_event_generator #(
   parameter int NUM_BUTTONS = bde_pkg::DEF_NUM_BUTTONS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bde_pkg::REQ_DATA_W-1:0] req_tdata,  // now_ms, raw_levels
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bde_pkg::RSP_DATA_W-1:0] rsp_tdata,  // button_index, event_time
   output logic [1:0]                     rsp_tuser,  // event_kind
   output logic                           rsp_tlast,  // last_event
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bde_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bde_pkg::CSR_DATA_W-1:0] csr_data
);
   import bde_pkg::*;

   localparam int USED  = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;
   localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
   localparam int CNT_W = $clog2(USED + 1);

   logic [TIMING_W-1:0] deb_time_ff;
   logic [TIMING_W-1:0] long_time_ff;
   logic [LANES-1:0]    active_ff;
   logic [3:0]          count_cfg_ff;

   logic [TIME_W-1:0]   now_ff;
   logic [LANES-1:0]    levels_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    idx_in;
   state_type           state_ff;
   state_type           state_in;

   logic [USED-1:0]     raw_ff;
   logic [USED-1:0]     stable_ff;
   logic [USED-1:0]     longrep_ff;
   logic [TIME_W-1:0]   lc_ff [USED];
   logic [TIME_W-1:0]   ps_ff [USED];

   logic [IDX_W-1:0]    lane;
   logic [BTN_W-1:0]    bit3;
   logic                raw_now;
   logic                changed;
   logic [TIME_W-1:0]   lc_eff;
   logic [TIME_W-1:0]   cmp_base;
   logic [TIMING_W-1:0] cmp_thr;
   logic                cmp_ge;
   logic                deb_hit;
   logic                long_hit;
   logic                last_btn;
   logic                accept;
   logic [CNT_W-1:0]    count_sat;

   evq_ctl_type         evq_ctl;
   evq_sts_type         evq_sts;
   event_type           ev;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_time_ff  <= RST_DEBOUNCE_TIME;
         long_time_ff <= RST_LONG_PRESS_TIME;
         active_ff    <= RST_ACTIVE_LEVELS;
         count_cfg_ff <= RST_BUTTON_COUNT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DEBOUNCE_TIME:   deb_time_ff  <= csr_data;
            REG_LONG_PRESS_TIME: long_time_ff <= csr_data;
            REG_ACTIVE_LEVELS:   active_ff    <= csr_data[LANES-1:0];
            REG_BUTTON_COUNT:    count_cfg_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // datapath around the shared unit
   assign lane     = idx_ff[IDX_W-1:0];
   assign bit3     = BTN_W'(idx_ff);
   assign raw_now  = levels_ff[bit3] == active_ff[bit3];
   assign changed  = raw_now != raw_ff[lane];
   assign lc_eff   = changed ? now_ff : lc_ff[lane];
   assign cmp_base = (state_ff == ST_LONG) ? ps_ff[lane] : lc_eff;
   assign cmp_thr  = (state_ff == ST_LONG) ? long_time_ff : deb_time_ff;
   assign deb_hit  = cmp_ge && (stable_ff[lane] != raw_now);
   assign long_hit = cmp_ge && stable_ff[lane] && !longrep_ff[lane];
   assign last_btn = CNT_W'(idx_ff + 1'b1) == count_ff;
   assign accept   = req_tvalid && req_tready;
   assign count_sat = (count_cfg_ff > 4'(USED)) ? CNT_W'(USED) : CNT_W'(count_cfg_ff);

   bde_cmp u_cmp (
      .now_ms    (now_ff),
      .base_ms   (cmp_base),
      .threshold (cmp_thr),
      .reached   (cmp_ge)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in   = '0;
               state_in = (count_sat == '0) ? ST_FLUSH : ST_DEB;
            end
         end
         ST_DEB: begin
            if (deb_hit && !evq_sts.push_ok) begin
               state_in = ST_DEB;
            end else if (deb_hit && !raw_now && !longrep_ff[lane]) begin
               state_in = ST_CLICK;
            end else begin
               state_in = ST_LONG;
            end
         end
         ST_CLICK: begin
            if (evq_sts.push_ok) begin
               state_in = last_btn ? ST_FLUSH : ST_DEB;
               idx_in   = CNT_W'(idx_ff + 1'b1);
            end
         end
         ST_LONG: begin
            if (!long_hit || evq_sts.push_ok) begin
               state_in = last_btn ? ST_FLUSH : ST_DEB;
               idx_in   = CNT_W'(idx_ff + 1'b1);
            end
         end
         ST_FLUSH: begin
            if (evq_sts.flush_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready       = 1'b0;
      evq_ctl.push     = 1'b0;
      evq_ctl.flush    = 1'b0;
      ev.button_index  = bit3;
      ev.kind          = KIND_PRESS;
      ev.event_time    = now_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DEB: begin
            evq_ctl.push = deb_hit;
            ev.kind      = raw_now ? KIND_PRESS : KIND_RELEASE;
         end
         ST_CLICK: begin
            evq_ctl.push = 1'b1;
            ev.kind      = KIND_CLICK;
         end
         ST_LONG: begin
            evq_ctl.push = long_hit;
            ev.kind      = KIND_LONG;
         end
         ST_FLUSH: begin
            evq_ctl.flush = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff    <= req_tdata[TIME_W-1:0];
         levels_ff <= req_tdata[TIME_W+LANES-1:TIME_W];
         count_ff  <= count_sat;
      end
   end

   // per-button state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff     <= '0;
         stable_ff  <= '0;
         longrep_ff <= '0;
         for (int i = 0; i < USED; i++) begin
            lc_ff[i] <= '0;
            ps_ff[i] <= '0;
         end
      end else begin
         if (state_ff == ST_DEB) begin
            raw_ff[lane] <= raw_now;
            if (changed) begin
               lc_ff[lane] <= now_ff;
            end
            if (deb_hit && evq_sts.push_ok) begin
               stable_ff[lane] <= raw_now;
               if (raw_now) begin
                  ps_ff[lane]      <= now_ff;
                  longrep_ff[lane] <= 1'b0;
               end
            end
         end
         if (state_ff == ST_LONG && long_hit && evq_sts.push_ok) begin
            longrep_ff[lane] <= 1'b1;
         end
      end
   end

   bde_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .ctl        (evq_ctl),
      .ev         (ev),
      .sts        (evq_sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sim/bde_event_checker.sv =====
// ----------------------------------------------------------------------------
// bde_event_checker
// Watches the tick, event and register channels of the button event generator.
// It keeps its own copy of the registers and of the per-button debounce state.
// For each accepted tick it predicts the events that tick raises. It compares
// every accepted event, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module bde_event_checker #(
   parameter int NUM_BUTTONS = bde_pkg::DEF_NUM_BUTTONS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bde_pkg::REQ_DATA_W-1:0] req_tdata,   // now_ms, raw_levels
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bde_pkg::RSP_DATA_W-1:0] rsp_tdata,   // button_index, event_time
   input  logic [1:0]                     rsp_tuser,   // event_kind
   input  logic                           rsp_tlast,   // last_event
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bde_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bde_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             events_pending,
   output int                             events_checked
);
   import bde_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [BTN_W-1:0]  button;
      kind_type          kind;
      logic [TIME_W-1:0] stamp;
      logic              last;
   } btn_event_type;

   btn_event_type expected_events [$];

   logic [TIMING_W-1:0] debounce_ms;
   logic [TIMING_W-1:0] long_ms;
   logic [LANES-1:0]    active_lv;
   logic [3:0]          used_count;

   logic              raw_on     [LANES];
   logic              stable_on  [LANES];
   logic              long_done  [LANES];
   logic [TIME_W-1:0] change_at  [LANES];
   logic [TIME_W-1:0] press_at   [LANES];

   int fails;
   int checked;

   task automatic add_event(input int b, input kind_type k, input logic [TIME_W-1:0] t);
      btn_event_type ev;
      ev.button = BTN_W'(b);
      ev.kind   = k;
      ev.stamp  = t;
      ev.last   = 1'b0;
      expected_events.push_back(ev);
   endtask

   task automatic predict_tick(input logic [TIME_W-1:0] now, input logic [LANES-1:0] lv);
      int lanes;
      int cap;
      int first_new;
      logic raw;
      logic [TIME_W-1:0] elapsed;
      btn_event_type tail;
      cap = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;
      lanes = int'(used_count);
      if (lanes > cap) lanes = cap;
      first_new = expected_events.size();
      for (int i = 0; i < lanes; i++) begin
         raw = (lv[i] == active_lv[i]);
         if (raw != raw_on[i]) begin
            raw_on[i] = raw;
            change_at[i] = now;
         end
         elapsed = now - change_at[i];
         if (elapsed >= TIME_W'(debounce_ms) && stable_on[i] != raw_on[i]) begin
            stable_on[i] = raw_on[i];
            if (stable_on[i]) begin
               press_at[i] = now;
               long_done[i] = 1'b0;
               add_event(i, KIND_PRESS, now);
            end else begin
               add_event(i, KIND_RELEASE, now);
               if (!long_done[i]) add_event(i, KIND_CLICK, now);
            end
         end
         elapsed = now - press_at[i];
         if (stable_on[i] && !long_done[i] && elapsed >= TIME_W'(long_ms)) begin
            long_done[i] = 1'b1;
            add_event(i, KIND_LONG, now);
         end
      end
      if (expected_events.size() > first_new) begin
         tail = expected_events.pop_back();
         tail.last = 1'b1;
         expected_events.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      btn_event_type exp_ev;
      logic [BTN_W-1:0]  got_btn;
      logic [TIME_W-1:0] got_time;
      if (reset) begin
         debounce_ms = RST_DEBOUNCE_TIME;
         long_ms     = RST_LONG_PRESS_TIME;
         active_lv   = RST_ACTIVE_LEVELS;
         used_count  = RST_BUTTON_COUNT;
         for (int i = 0; i < LANES; i++) begin
            raw_on[i]    = 1'b0;
            stable_on[i] = 1'b0;
            long_done[i] = 1'b0;
            change_at[i] = '0;
            press_at[i]  = '0;
         end
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_btn  = rsp_tdata[BTN_W-1:0];
            got_time = rsp_tdata[BTN_W+TIME_W-1:BTN_W];
            if (expected_events.size() == 0) begin
               fails++;
               if (fails <= MAX_REPORTS)
                  $display("unexpected event: btn %0d kind %0d time %h last %b",
                           got_btn, rsp_tuser, got_time, rsp_tlast);
            end else begin
               exp_ev = expected_events.pop_front();
               checked++;
               if (got_btn != exp_ev.button || rsp_tuser != exp_ev.kind ||
                   got_time != exp_ev.stamp || rsp_tlast != exp_ev.last) begin
                  fails++;
                  if (fails <= MAX_REPORTS)
                     $display("event mismatch: exp btn %0d kind %s time %h last %b, %s",
                              exp_ev.button, exp_ev.kind.name(), exp_ev.stamp, exp_ev.last,
                              $sformatf("got btn %0d kind %0d time %h last %b",
                                        got_btn, rsp_tuser, got_time, rsp_tlast));
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_tick(req_tdata[TIME_W-1:0], req_tdata[TIME_W+LANES-1:TIME_W]);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEBOUNCE_TIME:   debounce_ms = csr_data[TIMING_W-1:0];
               REG_LONG_PRESS_TIME: long_ms     = csr_data[TIMING_W-1:0];
               REG_ACTIVE_LEVELS:   active_lv   = csr_data[LANES-1:0];
               REG_BUTTON_COUNT:    used_count  = csr_data[3:0];
               default: ;
            endcase
         end
      end
      fail_count     <= fails;
      events_pending <= expected_events.size();
      events_checked <= checked;
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the button event generator.
// A directed run at the reset settings covers press, release, click, long
// press, bounce and timestamp wrap. Random ticks follow under several register
// settings, among them the extremes, zero and oversized button counts. The
// tick times hold and bounce and jump, and some ticks are noise. Sender idle
// and receiver stall vary by phase, and one long receiver hold-off fills the
// block. The checker instance predicts the events and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
   import bde_pkg::*;

   localparam int                   HALF_PERIOD   = 6;
   localparam int                   SETTLE_CYCLES = 48;
   localparam int                   HOLDOFF_LEN   = 400;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED    = 4'hF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int events_pending;
   int events_checked;

   int sender_idle_pct = 0;
   int rcv_stall_pct   = 0;
   int holdoff_seq     = 0;
   int holdoff_seen    = 0;
   int holdoff_left    = 0;
   int ticks_sent      = 0;
   int settings_used   = 1;

   logic [TIME_W-1:0] clock_ms = '0;
   logic [LANES-1:0]  pins     = '0;

   always #HALF_PERIOD clock = ~clock;

   button_debounce_event_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bde_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .events_pending (events_pending),
      .events_checked (events_checked)
   );

   always @(posedge clock) begin
      if (holdoff_seq != holdoff_seen) begin
         holdoff_seen <= holdoff_seq;
         holdoff_left <= HOLDOFF_LEN;
         rsp_tready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   task automatic send_tick(input logic [TIME_W-1:0] now, input logic [LANES-1:0] lv);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lv, now};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all registers, then a write to an unmapped index that must be ignored
   task automatic program_regs(input logic [TIMING_W-1:0] db, input logic [TIMING_W-1:0] lp,
                               input logic [LANES-1:0] act, input logic [3:0] cnt);
      csr_write(REG_DEBOUNCE_TIME, db);
      csr_write(REG_LONG_PRESS_TIME, lp);
      csr_write(REG_ACTIVE_LEVELS, {8'd0, act});
      csr_write(REG_BUTTON_COUNT, {12'd0, cnt});
      csr_write(REG_UNUSED, CSR_DATA_W'($urandom()));
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic run_random(input int n, input int step_hi, input int jump_hi);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 7) begin
            send_tick($urandom(), LANES'($urandom()));
         end else begin
            if (r < 15) clock_ms += $urandom_range(jump_hi);
            else clock_ms += $urandom_range(step_hi);
            if ($urandom_range(99) < 30) pins ^= LANES'($urandom()) & LANES'($urandom());
            send_tick(clock_ms, pins);
         end
      end
   endtask

   task automatic set_pace(input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      rcv_stall_pct = stall_pct;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: level 0 means pressed, eight buttons
      send_tick(32'd0, 8'hFF);
      send_tick(32'd3, 8'h00);
      send_tick(32'd23, 8'h00);
      send_tick(32'd500, 8'h00);
      send_tick(32'd1023, 8'h00);
      send_tick(32'd1030, 8'hFF);
      send_tick(32'd1049, 8'hFF);
      send_tick(32'd1050, 8'hFF);
      send_tick(32'd1060, 8'hFE);
      send_tick(32'd1062, 8'hFF);
      send_tick(32'd1064, 8'hFE);
      send_tick(32'd1084, 8'hFE);
      send_tick(32'd1090, 8'hFF);
      send_tick(32'd1110, 8'hFF);
      send_tick(32'hFFFF_FFF0, 8'h0F);
      send_tick(32'hFFFF_FFFF, 8'h0F);
      send_tick(32'h0000_0004, 8'h0F);
      send_tick(32'h0000_03EC, 8'h0F);
      send_tick(32'h0000_03F0, 8'hF0);
      send_tick(32'h0000_0404, 8'hF0);
      send_tick(32'h0000_0500, 8'hFF);
      send_tick(32'h0000_0514, 8'hFF);
      send_tick(32'h0000_0600, 8'h00);
      send_tick(32'h0000_0614, 8'h00);
      send_tick(32'h0000_09FC, 8'h00);
      drain();
      clock_ms = 32'h0000_1000;
      pins = 8'h00;

      // zero timings: press and long press in one tick, hold off the receiver
      program_regs(16'd0, 16'd0, 8'hFF, 4'd8);
      set_pace(0, 0);
      holdoff_seq++;
      run_random(60, 3, 50);
      drain();

      program_regs(16'd5, 16'd60, LANES'($urandom()), 4'd3);
      set_pace(57, 0);
      run_random(60, 8, 200);
      drain();

      // longest timings, count above the lane limit
      program_regs(16'hFFFF, 16'hFFFF, 8'h5A, 4'd15);
      set_pace(0, 57);
      run_random(55, 30000, 70000);
      drain();

      // no buttons in use
      program_regs(16'd1234, 16'd9, 8'h00, 4'd0);
      set_pace(30, 30);
      run_random(15, 20, 400);
      drain();

      program_regs(16'd12, 16'd300, LANES'($urandom()), 4'd1);
      set_pace(30, 30);
      run_random(55, 20, 600);
      drain();

      // cross the timestamp wrap
      program_regs(16'd3, 16'd40, LANES'($urandom()), 4'd8);
      set_pace(57, 57);
      clock_ms = 32'hFFFF_FF00;
      run_random(60, 6, 100);
      drain();

      $display("Ran %0d ticks under %0d register settings, %0d events checked",
               ticks_sent, settings_used, events_checked);
      $display("Mismatches: %0d, events still expected: %0d", fail_count, events_pending);
      if (fail_count == 0 && events_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(2 * HALF_PERIOD * 400000);
      $display("Timeout: the run did not complete");
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bde_pkg.sv
sv/bde_cmp.sv
sv/bde_evq.sv
sv/button_debounce_event_generator.sv
sim/bde_event_checker.sv
sim/tb.sv
